@@ src/grid_ray_first_solid_cell_macros.svh @@
// ----------------------------------------------------------------------------
// grid_ray_first_solid_cell_macros
// Assertion macros shared by the grid ray probe RTL. Every macro expects
// clk_i and rst_ni in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef GRID_RAY_FIRST_SOLID_CELL_MACROS_SVH
`define GRID_RAY_FIRST_SOLID_CELL_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define GRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/grc_pkg.sv @@
// ----------------------------------------------------------------------------
// grc_pkg
// Shared widths, defaults, codes and control structs of the grid ray probe.
// ----------------------------------------------------------------------------
package grc_pkg;

  // Fixed field widths
  localparam int COORD_W   = 18;
  localparam int CELL_W    = 8;
  localparam int DIM_W     = 9;
  localparam int CFG_IDX_W = 4;

  // Reset value of both bounds registers
  localparam logic [DIM_W-1:0] DIM_RESET = 9'd256;

  // Parameter defaults
  localparam int DEF_MAX_GRID_COLS = 256;
  localparam int DEF_MAX_GRID_ROWS = 256;
  localparam int DEF_MAX_STEPS     = 512;
  localparam int DEF_FRAC_BITS     = 8;

  // Item function codes
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_CAST  = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 4'd0,
    REG_GRID_HEIGHT = 4'd1
  } grc_reg_e;

  // Controller to datapath commands
  typedef struct packed {
    logic clear_en;   // clear one map entry
    logic item_take;  // input transaction completes
    logic diff_en;    // form deltas, directions and start cell
    logic init_en;    // form error term and step count
    logic walk_en;    // issue one probe and advance
    logic res_load;   // capture the walk result
    logic out_load;   // move the result into the output register
  } grc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;  // clearing pass at its last entry
    logic steps_zero;  // no steps left to issue
    logic probe_pend;  // a probe read is in flight
    logic probe_hit;   // the probe in flight found a solid cell
    logic out_free;    // output register can take a result
  } grc_sts_t;

endpackage

@@ src/grc_if.sv @@
// ----------------------------------------------------------------------------
// grc_if
// Valid/ready channels of the grid ray probe: items, results, configuration.
// ----------------------------------------------------------------------------
interface grc_item_if;
  import grc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [CELL_W-1:0]         cell_col;
  logic [CELL_W-1:0]         cell_row;
  logic                      cell_solid;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;

  modport source (output valid, func, cell_col, cell_row, cell_solid,
                  start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, func, cell_col, cell_row, cell_solid,
                  start_x, start_y, end_x, end_y, output ready);
endinterface

interface grc_result_if;
  import grc_pkg::*;
  logic              valid;
  logic              ready;
  logic              hit;
  logic [CELL_W-1:0] hit_col;
  logic [CELL_W-1:0] hit_row;
  logic              cut_short;

  modport source (output valid, hit, hit_col, hit_row, cut_short, input ready);
  modport sink   (input valid, hit, hit_col, hit_row, cut_short, output ready);
endinterface

interface grc_cfg_if;
  import grc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic [DIM_W-1:0]     wdata;

  modport source (output valid, reg_idx, wdata, input ready);
  modport sink   (input valid, reg_idx, wdata, output ready);
endinterface

@@ src/grc_ram.sv @@
// ----------------------------------------------------------------------------
// grc_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module grc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/grc_ctrl.sv @@
// ----------------------------------------------------------------------------
// grc_ctrl
// Sequencer of the grid ray probe: clearing pass, item intake, cast setup,
// walk and result handoff.
// ----------------------------------------------------------------------------
`include "grid_ray_first_solid_cell_macros.svh"

module grc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  logic               item_func_i,
  output logic               item_ready_o,
  input  grc_pkg::grc_sts_t  sts_i,
  output grc_pkg::grc_cmd_t  cmd_o
);
  import grc_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_DIFF  = 6'b000100,
    ST_INIT  = 6'b001000,
    ST_WALK  = 6'b010000,
    ST_DONE  = 6'b100000
  } grc_state_e;

  grc_state_e state_q, state_d;
  grc_cmd_t   cmd;
  logic       walk_end;

  // The walk ends on a hit or once the last probe has come back empty
  assign walk_end = sts_i.probe_hit || (sts_i.steps_zero && !sts_i.probe_pend);

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    cmd          = '0;
    item_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        item_ready_o = 1'b1;
        if (item_valid_i) begin
          cmd.item_take = 1'b1;
          if (item_func_i == FUNC_CAST) begin
            state_d = ST_DIFF;
          end
        end
      end
      ST_DIFF: begin
        cmd.diff_en = 1'b1;
        state_d     = ST_INIT;
      end
      ST_INIT: begin
        cmd.init_en = 1'b1;
        state_d     = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk_en = 1'b1;
        if (walk_end) begin
          cmd.res_load = 1'b1;
          state_d      = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign cmd_o = cmd;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `GRC_ASSERT_IMP(a_out_load_free, cmd.out_load, sts_i.out_free, "result loaded into busy output")
  `GRC_ASSERT_NEXT(a_cast_to_diff, cmd.item_take && (item_func_i == FUNC_CAST), state_q == ST_DIFF, "cast transaction did not start setup")
  `GRC_ASSERT_IMP(a_no_take_in_clear, state_q == ST_CLEAR, !cmd.item_take, "item taken during clearing pass")

endmodule

@@ src/grc_dpath.sv @@
// ----------------------------------------------------------------------------
// grc_dpath
// Datapath of the grid ray probe: solid map, bounds registers, cast setup,
// step engine with one speculative map read per cycle, result and output
// registers.
// ----------------------------------------------------------------------------
`include "grid_ray_first_solid_cell_macros.svh"

module grc_dpath #(
  parameter int MAX_GRID_COLS = grc_pkg::DEF_MAX_GRID_COLS,
  parameter int MAX_GRID_ROWS = grc_pkg::DEF_MAX_GRID_ROWS,
  parameter int MAX_STEPS     = grc_pkg::DEF_MAX_STEPS,
  parameter int FRAC_BITS     = grc_pkg::DEF_FRAC_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  grc_pkg::grc_cmd_t                  cmd_i,
  output grc_pkg::grc_sts_t                  sts_o,
  input  logic                               item_func_i,
  input  logic [grc_pkg::CELL_W-1:0]         cell_col_i,
  input  logic [grc_pkg::CELL_W-1:0]         cell_row_i,
  input  logic                               cell_solid_i,
  input  logic signed [grc_pkg::COORD_W-1:0] start_x_i,
  input  logic signed [grc_pkg::COORD_W-1:0] start_y_i,
  input  logic signed [grc_pkg::COORD_W-1:0] end_x_i,
  input  logic signed [grc_pkg::COORD_W-1:0] end_y_i,
  input  logic                               cfg_we_i,
  input  logic [grc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [grc_pkg::DIM_W-1:0]          cfg_wdata_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic                               hit_o,
  output logic [grc_pkg::CELL_W-1:0]         hit_col_o,
  output logic [grc_pkg::CELL_W-1:0]         hit_row_o,
  output logic                               cut_short_o
);
  import grc_pkg::*;

  localparam int COL_AW = $clog2(MAX_GRID_COLS);
  localparam int ROW_AW = $clog2(MAX_GRID_ROWS);
  localparam int ADDR_W = ROW_AW + COL_AW;
  localparam int DEPTH  = MAX_GRID_ROWS * (1 << COL_AW);
  localparam int STEP_W = $clog2(MAX_STEPS + 1);
  localparam int POS_W  = COORD_W - FRAC_BITS + $clog2(MAX_STEPS) + 1;
  localparam int SUM_W  = COORD_W + 1;
  localparam int ERR_W  = COORD_W + 3;
  localparam int CMP_W  = POS_W + 14;
  localparam logic [COORD_W-1:0] FRAC_MASK = COORD_W'((64'd1 << FRAC_BITS) - 64'd1);

  // Bounds registers
  logic [DIM_W-1:0] gw_q, gh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= DIM_RESET;
      gh_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (grc_reg_e'(cfg_idx_i))
        REG_GRID_WIDTH:  gw_q <= cfg_wdata_i;
        REG_GRID_HEIGHT: gh_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clearing pass address
  logic [ADDR_W-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear_en) begin
      clr_q <= clr_q + ADDR_W'(1);
    end
  end

  // Map write port: clearing pass or cell write
  logic              wr_in_range, ram_we, ram_wdata, ram_rdata;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;

  assign wr_in_range = (CMP_W'(cell_col_i) < CMP_W'(MAX_GRID_COLS)) &&
                       (CMP_W'(cell_row_i) < CMP_W'(MAX_GRID_ROWS));
  assign ram_we    = cmd_i.clear_en ||
                     (cmd_i.item_take && (item_func_i == FUNC_WRITE) && wr_in_range);
  assign ram_waddr = cmd_i.clear_en ? clr_q : {ROW_AW'(cell_row_i), COL_AW'(cell_col_i)};
  assign ram_wdata = cmd_i.clear_en ? 1'b0 : cell_solid_i;

  // Latch the segment of a cast
  logic signed [COORD_W-1:0] sx_q, sy_q, ex_q, ey_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_take && (item_func_i == FUNC_CAST)) begin
      sx_q <= start_x_i;
      sy_q <= start_y_i;
      ex_q <= end_x_i;
      ey_q <= end_y_i;
    end
  end

  // Setup, first cycle: deltas, directions, start cell truncated toward zero
  logic signed [SUM_W-1:0]   diff_x, diff_y;
  logic [COORD_W-1:0]        absx, absy;
  logic                      xpos_d, ypos_d;
  logic signed [COORD_W-1:0] sx_fl, sy_fl;
  logic                      sx_adj, sy_adj;

  always_comb begin
    diff_x = SUM_W'(ex_q) - SUM_W'(sx_q);
    diff_y = SUM_W'(ey_q) - SUM_W'(sy_q);
    absx   = diff_x[SUM_W-1] ? COORD_W'(-diff_x) : COORD_W'(diff_x);
    absy   = diff_y[SUM_W-1] ? COORD_W'(-diff_y) : COORD_W'(diff_y);
    xpos_d = !diff_x[SUM_W-1] && (diff_x != '0);
    ypos_d = !diff_y[SUM_W-1] && (diff_y != '0);
    sx_fl  = sx_q >>> FRAC_BITS;
    sy_fl  = sy_q >>> FRAC_BITS;
    sx_adj = sx_q[COORD_W-1] && ((sx_q & FRAC_MASK) != '0);
    sy_adj = sy_q[COORD_W-1] && ((sy_q & FRAC_MASK) != '0);
  end

  // Absolute deltas captured by the first setup cycle
  logic [COORD_W-1:0] dx_q, dy_q;

  // Setup, second cycle: error term and step count with clamp
  logic [SUM_W-1:0]        sum, sum_sh;
  logic                    clamp_d;
  logic [STEP_W-1:0]       steps_init;
  logic signed [ERR_W-1:0] err_init;

  always_comb begin
    sum        = SUM_W'(dx_q) + SUM_W'(dy_q);
    sum_sh     = sum >> FRAC_BITS;
    clamp_d    = sum_sh >= SUM_W'(MAX_STEPS);
    steps_init = clamp_d ? STEP_W'(MAX_STEPS) : STEP_W'(sum_sh) + STEP_W'(1);
    err_init   = $signed(ERR_W'(dx_q)) - $signed(ERR_W'(dy_q));
  end

  // Step engine
  logic                    xpos_q, ypos_q, clamp_q;
  logic [POS_W-1:0]        x_q, y_q, x_d, y_d;
  logic signed [ERR_W-1:0] err_q, err_d;
  logic [STEP_W-1:0]       steps_q, steps_d;
  logic                    steps_zero, issue, err_pos, in_bounds;
  logic [ERR_W-1:0]        dx2, dy2;

  assign steps_zero = (steps_q == '0);
  assign issue      = cmd_i.walk_en && !steps_zero;
  assign err_pos    = !err_q[ERR_W-1] && (err_q != '0);
  assign dx2        = ERR_W'({dx_q, 1'b0});
  assign dy2        = ERR_W'({dy_q, 1'b0});
  assign in_bounds  = !x_q[POS_W-1] && !y_q[POS_W-1] &&
                      (CMP_W'($unsigned(x_q)) < CMP_W'(gw_q)) &&
                      (CMP_W'($unsigned(x_q)) < CMP_W'(MAX_GRID_COLS)) &&
                      (CMP_W'($unsigned(y_q)) < CMP_W'(gh_q)) &&
                      (CMP_W'($unsigned(y_q)) < CMP_W'(MAX_GRID_ROWS));

  always_comb begin
    x_d     = x_q;
    y_d     = y_q;
    err_d   = err_q;
    steps_d = steps_q;
    if (cmd_i.diff_en) begin
      x_d = POS_W'(sx_fl) + POS_W'(sx_adj);
      y_d = POS_W'(sy_fl) + POS_W'(sy_adj);
    end else if (cmd_i.init_en) begin
      err_d   = err_init;
      steps_d = steps_init;
    end else if (issue) begin
      steps_d = steps_q - STEP_W'(1);
      if (err_pos) begin
        x_d   = xpos_q ? x_q + POS_W'(1) : x_q - POS_W'(1);
        err_d = err_q - $signed(dy2);
      end else begin
        y_d   = ypos_q ? y_q + POS_W'(1) : y_q - POS_W'(1);
        err_d = err_q + $signed(dx2);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    err_q <= err_d;
    if (cmd_i.diff_en) begin
      dx_q   <= absx;
      dy_q   <= absy;
      xpos_q <= xpos_d;
      ypos_q <= ypos_d;
    end
    if (cmd_i.init_en) begin
      clamp_q <= clamp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
    end else begin
      steps_q <= steps_d;
    end
  end

  // Probe in flight: cell of the read issued last cycle
  logic              probe_pend_q, probe_ok_q, probe_hit;
  logic [COL_AW-1:0] probe_col_q;
  logic [ROW_AW-1:0] probe_row_q;

  assign ram_raddr = {ROW_AW'($unsigned(y_q)), COL_AW'($unsigned(x_q))};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_pend_q <= 1'b0;
    end else begin
      probe_pend_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      probe_ok_q  <= in_bounds;
      probe_col_q <= COL_AW'($unsigned(x_q));
      probe_row_q <= ROW_AW'($unsigned(y_q));
    end
  end

  assign probe_hit = probe_pend_q && probe_ok_q && ram_rdata;

  grc_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Hold the walk result until the output register is free
  logic              res_hit_q, res_cut_q;
  logic [CELL_W-1:0] res_col_q, res_row_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_hit_q <= probe_hit;
      res_col_q <= probe_hit ? CELL_W'(probe_col_q) : '0;
      res_row_q <= probe_hit ? CELL_W'(probe_row_q) : '0;
      res_cut_q <= clamp_q;
    end
  end

  // Output register
  logic              out_valid_q, out_hit_q, out_cut_q;
  logic [CELL_W-1:0] out_col_q, out_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_hit_q <= res_hit_q;
      out_col_q <= res_col_q;
      out_row_q <= res_row_q;
      out_cut_q <= res_cut_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_hit_q;
  assign hit_col_o   = out_col_q;
  assign hit_row_o   = out_row_q;
  assign cut_short_o = out_cut_q;

  // Status
  assign sts_o.clear_last = (clr_q == ADDR_W'(DEPTH - 1));
  assign sts_o.steps_zero = steps_zero;
  assign sts_o.probe_pend = probe_pend_q;
  assign sts_o.probe_hit  = probe_hit;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  `GRC_ASSERT_IMP(a_steps_bound, 1'b1, steps_q <= STEP_W'(MAX_STEPS), "step count above maximum")
  `GRC_ASSERT_IMP(a_no_write_in_walk, cmd_i.walk_en, !ram_we, "map written during a walk")
  `GRC_ASSERT_IMP(a_hit_in_bounds, cmd_i.res_load && probe_hit, (CMP_W'(probe_col_q) < CMP_W'(gw_q)) && (CMP_W'(probe_row_q) < CMP_W'(gh_q)), "hit outside configured bounds")

endmodule

@@ src/grid_ray_first_solid_cell.sv @@
// ----------------------------------------------------------------------------
// grid_ray_first_solid_cell
// Grid ray probe: solid/empty cell map with a 4-connected walk that reports
// the first in-bounds solid cell along a fixed-point segment.
// ----------------------------------------------------------------------------
// After reset the block sweeps the cell map empty, one entry per cycle, over
// all MAX_GRID_ROWS * 2**clog2(MAX_GRID_COLS) entries (65536 with the
// defaults); the item channel stays not ready during the sweep, while
// configuration writes are taken at any time. A write item goes to the map
// as it is taken. A cast probes up to k = min(MAX_STEPS, 1 + trunc(dx + dy))
// cells, stopping at the first solid in-bounds cell, after a setup that forms
// deltas, directions and start cell, then error term and step count. The
// result may then wait for the output register. The walk probes one cell per
// cycle through the single read port of the map; the read is registered, so
// the last probe answers in the cycle after it, and a walk without a hit ends
// once no probe is left in flight. The result sits in an output register, so
// a new item is taken while a finished result waits to be read.
// ----------------------------------------------------------------------------
module grid_ray_first_solid_cell #(
  parameter int MAX_GRID_COLS = grc_pkg::DEF_MAX_GRID_COLS,
  parameter int MAX_GRID_ROWS = grc_pkg::DEF_MAX_GRID_ROWS,
  parameter int MAX_STEPS     = grc_pkg::DEF_MAX_STEPS,
  parameter int FRAC_BITS     = grc_pkg::DEF_FRAC_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  grc_item_if.sink     item_i,
  grc_result_if.source result_o,
  grc_cfg_if.sink      cfg_i
);
  import grc_pkg::*;

  grc_cmd_t cmd;
  grc_sts_t sts;

  // Configuration writes are always taken
  assign cfg_i.ready = 1'b1;

  grc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_func_i  (item_i.func),
    .item_ready_o (item_i.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  grc_dpath #(
    .MAX_GRID_COLS (MAX_GRID_COLS),
    .MAX_GRID_ROWS (MAX_GRID_ROWS),
    .MAX_STEPS     (MAX_STEPS),
    .FRAC_BITS     (FRAC_BITS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .item_func_i  (item_i.func),
    .cell_col_i   (item_i.cell_col),
    .cell_row_i   (item_i.cell_row),
    .cell_solid_i (item_i.cell_solid),
    .start_x_i    (item_i.start_x),
    .start_y_i    (item_i.start_y),
    .end_x_i      (item_i.end_x),
    .end_y_i      (item_i.end_y),
    .cfg_we_i     (cfg_i.valid),
    .cfg_idx_i    (cfg_i.reg_idx),
    .cfg_wdata_i  (cfg_i.wdata),
    .out_ready_i  (result_o.ready),
    .out_valid_o  (result_o.valid),
    .hit_o        (result_o.hit),
    .hit_col_o    (result_o.hit_col),
    .hit_row_o    (result_o.hit_row),
    .cut_short_o  (result_o.cut_short)
  );

endmodule
